// File: rtl/tmh_pkg.sv
// Package for the timer min-heap: sizes, command and status codes,
// sequencer states and the wrap-safe time compare. No dependencies.
package tmh_pkg;

    localparam int CAPACITY = 32;
    localparam int ID_COUNT = 256;
    localparam int TIME_W   = 32;
    localparam int ID_W     = 8;
    localparam int WAIT_W   = 31;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = IDX_W + 1;
    localparam int ENTRY_W  = ID_W + TIME_W;

    typedef enum logic [2:0] {
        CMD_ADD   = 3'd0,
        CMD_UPD   = 3'd1,
        CMD_DEL   = 3'd2,
        CMD_FIRE  = 3'd3,
        CMD_TICK  = 3'd4,
        CMD_POP   = 3'd5,
        CMD_CLEAR = 3'd6,
        CMD_NOP   = 3'd7
    } t_cmd;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    localparam logic KIND_FIRED = 1'b0;
    localparam logic KIND_DONE  = 1'b1;

    localparam logic [WAIT_W-1:0] WAIT_MAX = {WAIT_W{1'b1}};

    typedef enum logic [4:0] {
        S_IDLE,
        S_POS,
        S_RM,
        S_LAST,
        S_DN,
        S_DN_L,
        S_DN_R,
        S_DN_CMP,
        S_UP,
        S_UP_CMP,
        S_PLACE,
        S_OPEND,
        S_TICK,
        S_TICK_CHK,
        S_POP,
        S_EMIT,
        S_EMIT_F
    } t_state;

    // True when time a lies strictly after time b
    function automatic logic after_t(input logic [TIME_W-1:0] a,
                                     input logic [TIME_W-1:0] b);
        logic [TIME_W-1:0] d;
        d = a - b;
        return (d != '0) && !d[TIME_W-1];
    endfunction

endpackage

// File: rtl/tmh_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tmh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: rtl/timer_min_heap_with_id_index.sv
// Timer queue top level: binary min-heap of (id, expiry) in RAM, per-id slot RAM,
// fired-id buffer RAM and the sequencer around one shared time compare.
// Depends on tmh_pkg and tmh_ram.
//
// Usage:
//   Command channel: drive i_command, i_timer_id, i_timeout_ms, i_now_ms and raise
//   start; the item is taken at a clock edge with start high and busy low. busy
//   stays high until the last result of the item has been registered.
//   Result channel: each result sits on the o_ ports for one cycle with o_strobe
//   high; o_last marks the final (command done) result, which is on the ports in
//   the first cycle with busy low. The receiver cannot stall; results are simply
//   presented one per strobe.
//   Timing: every heap access is a RAM read with registered read data, so the
//   sift loop sets the pace: going down, each level reads the left child, then
//   the right child if there is one, then compares; going up, each level reads
//   the parent, then compares. Clear and unknown codes go straight to the done
//   result, a missing id or a full heap after the slot lookup. Each fired result
//   is read from the fired-id buffer and then presented, the done result last.
//   Reset (i_rst_n low at a clock edge) empties the queue: all ids are marked
//   absent and the count goes to zero at once, no clearing pass is needed.
module timer_min_heap_with_id_index (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [2:0]                  i_command,
    input  logic [tmh_pkg::ID_W-1:0]    i_timer_id,
    input  logic [tmh_pkg::WAIT_W-1:0]  i_timeout_ms,
    input  logic [tmh_pkg::TIME_W-1:0]  i_now_ms,
    output logic                        o_strobe,
    output logic                        o_event_kind,
    output logic [tmh_pkg::ID_W-1:0]    o_fired_id,
    output logic [tmh_pkg::WAIT_W-1:0]  o_wait_ms,
    output logic [tmh_pkg::CNT_W-1:0]   o_live_count,
    output logic [1:0]                  o_status,
    output logic                        o_last
);
    import tmh_pkg::*;

    t_state r_state, n_state;
    t_cmd   r_cmd;

    logic [ID_W-1:0]   r_id;
    logic [TIME_W-1:0] r_exp, r_now;
    logic [CNT_W-1:0]  r_live, r_fcnt, r_ecnt, r_j;
    logic [IDX_W-1:0]  r_i, r_start;
    logic [ID_W-1:0]   r_e_id, r_c_id, r_done_id;
    logic [TIME_W-1:0] r_e_exp, r_c_exp;
    logic [1:0]        r_status;
    logic [WAIT_W-1:0] r_wait;
    logic              r_present [ID_COUNT];

    // RAM ports
    logic               hp_we;
    logic [IDX_W-1:0]   hp_waddr, hp_raddr;
    logic [ENTRY_W-1:0] hp_wdata, hp_rd;
    logic               ps_we;
    logic [ID_W-1:0]    ps_waddr;
    logic [IDX_W-1:0]   ps_rd;
    logic               fb_we;
    logic [IDX_W-1:0]   fb_waddr;
    logic [ID_W-1:0]    fb_wdata, fb_rd;

    logic [ID_W-1:0]   hp_rd_id;
    logic [TIME_W-1:0] hp_rd_exp;
    assign hp_rd_id  = hp_rd[ENTRY_W-1:TIME_W];
    assign hp_rd_exp = hp_rd[TIME_W-1:0];

    // index arithmetic
    logic              known;
    logic [CNT_W-1:0]  j_w, lastpos;
    logic [CNT_W:0]    j1;
    logic [IDX_W-1:0]  par;
    logic              has_l, has_r, rm_move, full;
    assign known   = r_present[r_id];
    assign j_w     = {r_i, 1'b1};
    assign j1      = {1'b0, j_w} + 1'b1;
    assign par     = (r_i - 1'b1) >> 1;
    assign has_l   = j_w < r_live;
    assign has_r   = j1 < {1'b0, r_live};
    assign lastpos = r_live - 1'b1;
    assign rm_move = {1'b0, r_i} < lastpos;
    assign full    = r_live >= CNT_W'(CAPACITY);
    assign busy    = r_state != S_IDLE;

    // shared time compare unit
    logic [TIME_W-1:0] cmp_a, cmp_b, wdiff;
    logic              cmp_gt;
    always_comb begin
        case (r_state)
            S_DN_R: begin
                cmp_a = r_c_exp;
                cmp_b = hp_rd_exp;
            end
            S_DN_CMP: begin
                cmp_a = r_e_exp;
                cmp_b = r_c_exp;
            end
            S_UP_CMP: begin
                cmp_a = hp_rd_exp;
                cmp_b = r_e_exp;
            end
            S_TICK_CHK: begin
                cmp_a = hp_rd_exp;
                cmp_b = r_now;
            end
            default: begin
                cmp_a = '0;
                cmp_b = '0;
            end
        endcase
    end
    assign cmp_gt = after_t(cmp_a, cmp_b);
    assign wdiff  = hp_rd_exp - r_now;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (t_cmd'(i_command))
                        CMD_ADD, CMD_UPD, CMD_DEL, CMD_FIRE: n_state = S_POS;
                        CMD_TICK: n_state = S_TICK;
                        CMD_POP:  n_state = (r_live == '0) ? S_EMIT : S_POP;
                        default:  n_state = S_EMIT;
                    endcase
                end
            end
            S_POS: begin
                case (r_cmd)
                    CMD_ADD: n_state = known ? S_DN : (full ? S_EMIT : S_UP);
                    CMD_UPD: n_state = known ? S_DN : S_EMIT;
                    CMD_DEL, CMD_FIRE: n_state = known ? S_RM : S_EMIT;
                    default: n_state = S_EMIT;
                endcase
            end
            S_RM:     n_state = rm_move ? S_LAST : S_OPEND;
            S_LAST:   n_state = S_DN;
            S_DN:     n_state = has_l ? S_DN_L : ((r_i == r_start) ? S_UP : S_PLACE);
            S_DN_L:   n_state = has_r ? S_DN_R : S_DN_CMP;
            S_DN_R:   n_state = S_DN_CMP;
            S_DN_CMP: n_state = cmp_gt ? S_DN : ((r_i == r_start) ? S_UP : S_PLACE);
            S_UP:     n_state = (r_i == '0) ? S_PLACE : S_UP_CMP;
            S_UP_CMP: n_state = cmp_gt ? S_UP : S_PLACE;
            S_PLACE:  n_state = S_OPEND;
            S_OPEND:  n_state = (r_cmd == CMD_TICK) ? S_TICK : S_EMIT;
            S_TICK:   n_state = (r_live != '0) ? S_TICK_CHK : S_EMIT;
            S_TICK_CHK: n_state = cmp_gt ? S_EMIT : S_RM;
            S_POP:    n_state = S_RM;
            S_EMIT:   n_state = (r_ecnt < r_fcnt) ? S_EMIT_F : S_IDLE;
            S_EMIT_F: n_state = S_EMIT;
            default:  n_state = S_IDLE;
        endcase
    end

    // RAM controls
    always_comb begin
        hp_raddr = '0;
        hp_we    = 1'b0;
        hp_waddr = r_i;
        hp_wdata = {r_e_id, r_e_exp};
        fb_we    = 1'b0;
        fb_waddr = r_fcnt[IDX_W-1:0];
        fb_wdata = r_id;
        case (r_state)
            S_RM:   hp_raddr = lastpos[IDX_W-1:0];
            S_DN:   hp_raddr = j_w[IDX_W-1:0];
            S_DN_L: hp_raddr = j1[IDX_W-1:0];
            S_UP:   hp_raddr = par;
            S_POS:  fb_we    = (r_cmd == CMD_FIRE) && known;
            S_DN_CMP: begin
                hp_we    = cmp_gt;
                hp_wdata = {r_c_id, r_c_exp};
            end
            S_UP_CMP: begin
                hp_we    = cmp_gt;
                hp_wdata = hp_rd;
            end
            S_PLACE: hp_we = 1'b1;
            S_TICK_CHK: begin
                fb_we    = !cmp_gt;
                fb_wdata = hp_rd_id;
            end
            default: hp_raddr = '0;
        endcase
        ps_we    = hp_we;
        ps_waddr = hp_wdata[ENTRY_W-1:TIME_W];
    end

    tmh_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_heap (
        .i_clk   (i_clk),
        .i_we    (hp_we),
        .i_waddr (hp_waddr),
        .i_wdata (hp_wdata),
        .i_raddr (hp_raddr),
        .o_rdata (hp_rd)
    );

    tmh_ram #(.WIDTH(IDX_W), .DEPTH(ID_COUNT)) u_pos (
        .i_clk   (i_clk),
        .i_we    (ps_we),
        .i_waddr (ps_waddr),
        .i_wdata (r_i),
        .i_raddr (i_timer_id),
        .o_rdata (ps_rd)
    );

    tmh_ram #(.WIDTH(ID_W), .DEPTH(CAPACITY)) u_fired (
        .i_clk   (i_clk),
        .i_we    (fb_we),
        .i_waddr (fb_waddr),
        .i_wdata (fb_wdata),
        .i_raddr (r_ecnt[IDX_W-1:0]),
        .o_rdata (fb_rd)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_live   <= '0;
            o_strobe <= 1'b0;
            for (int k = 0; k < ID_COUNT; k++) begin
                r_present[k] <= 1'b0;
            end
        end else begin
            r_state  <= n_state;
            o_strobe <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start && (t_cmd'(i_command) == CMD_CLEAR)) begin
                        r_live <= '0;
                        for (int k = 0; k < ID_COUNT; k++) begin
                            r_present[k] <= 1'b0;
                        end
                    end
                end
                S_POS: begin
                    if (r_cmd == CMD_ADD && !known && !full) begin
                        r_live          <= r_live + 1'b1;
                        r_present[r_id] <= 1'b1;
                    end else if ((r_cmd == CMD_DEL || r_cmd == CMD_FIRE) && known) begin
                        r_present[r_id] <= 1'b0;
                    end
                end
                S_RM: begin
                    if (!rm_move) r_live <= lastpos;
                end
                S_LAST: r_live <= lastpos;
                S_TICK_CHK: begin
                    if (!cmp_gt) r_present[hp_rd_id] <= 1'b0;
                end
                S_POP: r_present[hp_rd_id] <= 1'b0;
                S_EMIT: begin
                    if (r_ecnt >= r_fcnt) o_strobe <= 1'b1;
                end
                S_EMIT_F: o_strobe <= 1'b1;
                default: r_live <= r_live;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    r_cmd     <= t_cmd'(i_command);
                    r_id      <= i_timer_id;
                    r_exp     <= i_now_ms + TIME_W'(i_timeout_ms);
                    r_now     <= i_now_ms;
                    r_status  <= (t_cmd'(i_command) == CMD_POP && r_live == '0)
                                 ? ST_EMPTY : ST_OK;
                    r_done_id <= '0;
                    r_wait    <= '0;
                    r_fcnt    <= '0;
                    r_ecnt    <= '0;
                end
            end
            S_POS: begin
                r_e_id  <= r_id;
                r_e_exp <= r_exp;
                r_i     <= ps_rd;
                r_start <= ps_rd;
                case (r_cmd)
                    CMD_ADD: begin
                        if (!known && full) begin
                            r_status <= ST_FULL;
                        end else if (!known) begin
                            r_i     <= r_live[IDX_W-1:0];
                            r_start <= r_live[IDX_W-1:0];
                        end
                    end
                    CMD_FIRE: begin
                        if (known) r_fcnt <= r_fcnt + 1'b1;
                        else r_status <= ST_NOTFOUND;
                    end
                    default: begin
                        if (!known) r_status <= ST_NOTFOUND;
                    end
                endcase
            end
            S_LAST: begin
                r_e_id  <= hp_rd_id;
                r_e_exp <= hp_rd_exp;
                r_start <= r_i;
            end
            S_DN_L: begin
                r_c_id  <= hp_rd_id;
                r_c_exp <= hp_rd_exp;
                r_j     <= j_w;
            end
            S_DN_R: begin
                if (cmp_gt) begin
                    r_c_id  <= hp_rd_id;
                    r_c_exp <= hp_rd_exp;
                    r_j     <= j1[CNT_W-1:0];
                end
            end
            S_DN_CMP: begin
                if (cmp_gt) r_i <= r_j[IDX_W-1:0];
            end
            S_UP_CMP: begin
                if (cmp_gt) r_i <= par;
            end
            S_TICK_CHK: begin
                if (!cmp_gt) begin
                    r_fcnt <= r_fcnt + 1'b1;
                    r_i    <= '0;
                end else begin
                    r_wait <= wdiff[TIME_W-1:WAIT_W] != '0 ? WAIT_MAX
                                                           : wdiff[WAIT_W-1:0];
                end
            end
            S_POP: begin
                r_done_id <= hp_rd_id;
                r_i       <= '0;
            end
            S_EMIT: begin
                o_event_kind <= KIND_DONE;
                o_fired_id   <= r_done_id;
                o_wait_ms    <= r_wait;
                o_live_count <= r_live;
                o_status     <= r_status;
                o_last       <= 1'b1;
            end
            S_EMIT_F: begin
                o_event_kind <= KIND_FIRED;
                o_fired_id   <= fb_rd;
                o_wait_ms    <= '0;
                o_live_count <= r_live;
                o_status     <= ST_OK;
                o_last       <= 1'b0;
                r_ecnt       <= r_ecnt + 1'b1;
            end
            default: r_id <= r_id;
        endcase
    end
endmodule

// File: rtl/tmh_chk.sv
// Port-level checker for the timer min-heap and its bind to the top level.
// Depends on tmh_pkg.
module tmh_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        o_strobe,
    input logic                        o_event_kind,
    input logic [tmh_pkg::WAIT_W-1:0]  o_wait_ms,
    input logic [tmh_pkg::CNT_W-1:0]   o_live_count,
    input logic [1:0]                  o_status,
    input logic                        o_last
);
    import tmh_pkg::*;

    // an accepted item keeps the block busy in the next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("item accepted but block not busy");

    // done results and last coincide
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_last == (o_event_kind == KIND_DONE)))
        else $error("last flag does not match done result");

    // fired results carry no wait and no error
    a_fired: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_event_kind == KIND_FIRED |-> o_status == ST_OK && o_wait_ms == '0)
        else $error("fired result with status or wait");

    // the count never exceeds capacity
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> o_live_count <= CNT_W'(CAPACITY))
        else $error("live count above capacity");

    // consecutive fired results of one item keep the same count
    a_same: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last ##2 o_strobe |-> $stable(o_live_count))
        else $error("live count changed within one item");
endmodule

bind timer_min_heap_with_id_index tmh_chk u_tmh_chk (.*);
